@@ rtl/dcmma_pkg.sv @@
// Package for the dual-channel min/max and moving-average core.
// Holds default sizes, the fixed-point format, the config width and the sequencer states.
// No dependencies.
package dcmma_pkg;

	localparam int WINDOW_MAX_DEF  = 16;
	localparam int SAMPLE_BITS_DEF = 16;
	localparam int FRAC_BITS       = 8;
	localparam int CFG_BITS        = 5;

	localparam logic [CFG_BITS-1:0] WINDOW_LENGTH_RESET = CFG_BITS'(5);

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_ACC,
		ST_DIV,
		ST_FIN
	} state_t;

endpackage

@@ rtl/dcmma_if.sv @@
// Valid/ready channel interfaces for the sample input and the result output.
// Depends on dcmma_pkg for default widths and the fraction width.
interface dcmma_in_if #(
	parameter int SAMPLE_BITS = dcmma_pkg::SAMPLE_BITS_DEF
);
	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] current_sample;
	logic signed [SAMPLE_BITS-1:0] temperature_sample;

	modport source (output valid, current_sample, temperature_sample, input ready);
	modport sink   (input valid, current_sample, temperature_sample, output ready);
endinterface

interface dcmma_out_if #(
	parameter int SAMPLE_BITS = dcmma_pkg::SAMPLE_BITS_DEF
);
	localparam int AVG_BITS = SAMPLE_BITS + dcmma_pkg::FRAC_BITS;

	logic                          valid;
	logic                          ready;
	logic signed [SAMPLE_BITS-1:0] min_temperature;
	logic signed [SAMPLE_BITS-1:0] max_temperature;
	logic signed [AVG_BITS-1:0]    avg_temperature;
	logic signed [SAMPLE_BITS-1:0] min_current;
	logic signed [SAMPLE_BITS-1:0] max_current;
	logic signed [AVG_BITS-1:0]    avg_current;

	modport source (output valid, min_temperature, max_temperature, avg_temperature,
		min_current, max_current, avg_current, input ready);
	modport sink   (input valid, min_temperature, max_temperature, avg_temperature,
		min_current, max_current, avg_current, output ready);
endinterface

@@ rtl/dual_channel_min_max_moving_average_core.sv @@
// Top level: running min/max and windowed average for a current and a temperature channel.
// Depends on dcmma_pkg and the channel interfaces in dcmma_if.sv.
//
//   channel   direction  payload                                     transfer
//   in_ch     sink       current_sample, temperature_sample          valid && ready
//   out_ch    source     min/max/avg for temperature, then current   valid && ready
//   cfg       write      cfg_data = window_length                    cfg_we
//
// Per item the sequencer steps IDLE, ACC, DIV, FIN. ACC sums the newest n entries,
// n = min(samples seen, window length): the history ring gives one entry per cycle to the
// sum, and radix-4 restoring dividers, one per lane, produce two quotient bits per cycle
// each (ITER = 15 at default sizes). in_ch is ready only while the sequencer is idle.
// A finished result waits in the output register; the next input is taken meanwhile and
// only the final load stalls if out_ch has not taken the previous one. No clearing pass.
module dual_channel_min_max_moving_average_core #(
	parameter int WINDOW_MAX  = dcmma_pkg::WINDOW_MAX_DEF,
	parameter int SAMPLE_BITS = dcmma_pkg::SAMPLE_BITS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           cfg_we,
	input  logic [dcmma_pkg::CFG_BITS-1:0] cfg_data,
	dcmma_in_if.sink                       in_ch,
	dcmma_out_if.source                    out_ch
);

	localparam int FRAC_BITS = dcmma_pkg::FRAC_BITS;
	localparam int AVG_BITS  = SAMPLE_BITS + FRAC_BITS;
	localparam int CNT_BITS  = $clog2(WINDOW_MAX + 1);
	localparam int PTR_BITS  = (WINDOW_MAX > 1) ? $clog2(WINDOW_MAX) : 1;
	localparam int SUM_BITS  = SAMPLE_BITS + CNT_BITS;
	localparam int DVD_BITS  = SUM_BITS + FRAC_BITS;
	localparam int DVD_EVEN  = DVD_BITS + (DVD_BITS % 2);
	localparam int ITER      = DVD_EVEN / 2;
	localparam int STEP_BITS = $clog2(ITER + 1);
	localparam int LANE_CUR  = 0;
	localparam int LANE_TMP  = 1;

	function automatic logic [CNT_BITS:0] div_bit(
		input logic [CNT_BITS-1:0] rem,
		input logic                b,
		input logic [CNT_BITS-1:0] d
	);
		logic [CNT_BITS:0] t;
		logic [CNT_BITS:0] diff;
		t    = {rem, b};
		diff = t - {1'b0, d};
		if (t >= {1'b0, d}) begin
			div_bit = {diff[CNT_BITS-1:0], 1'b1};
		end else begin
			div_bit = {t[CNT_BITS-1:0], 1'b0};
		end
	endfunction

	dcmma_pkg::state_t state_q, state_d;

	logic [dcmma_pkg::CFG_BITS-1:0] window_length_q;
	logic [PTR_BITS-1:0]            head_q, head_nx, rd_ptr_q, rd_ptr_nx;
	logic [CNT_BITS-1:0]            seen_q, seen_inc, len_eff, n_eff, len_q, cnt_q;
	logic [STEP_BITS-1:0]           step_q;
	logic                           rd_vld_s1;
	logic                           out_valid_q;
	logic                           in_xfer, acc_done, out_load;

	logic signed [SAMPLE_BITS-1:0] hist_q [2][WINDOW_MAX];
	logic signed [SAMPLE_BITS-1:0] samp   [2];
	logic signed [SAMPLE_BITS-1:0] rd_s1  [2];
	logic signed [SAMPLE_BITS-1:0] min_q  [2];
	logic signed [SAMPLE_BITS-1:0] max_q  [2];
	logic signed [SUM_BITS-1:0]    sum_q  [2];
	logic        [SUM_BITS-1:0]    mag    [2];
	logic        [DVD_EVEN-1:0]    dvd_q  [2];
	logic        [DVD_EVEN-1:0]    quo_q  [2];
	logic        [DVD_EVEN-1:0]    quo_ng [2];
	logic        [CNT_BITS-1:0]    rem_q  [2];
	logic        [CNT_BITS:0]      div_a  [2];
	logic        [CNT_BITS:0]      div_b  [2];
	logic                          neg_q  [2];
	logic        [AVG_BITS-1:0]    avg    [2];

	logic signed [SAMPLE_BITS-1:0] out_min_q [2];
	logic signed [SAMPLE_BITS-1:0] out_max_q [2];
	logic        [AVG_BITS-1:0]    out_avg_q [2];

	assign samp[LANE_CUR] = in_ch.current_sample;
	assign samp[LANE_TMP] = in_ch.temperature_sample;

	assign in_xfer  = in_ch.valid && in_ch.ready;
	assign acc_done = (cnt_q == '0) && !rd_vld_s1;
	assign head_nx  = (head_q == PTR_BITS'(WINDOW_MAX - 1)) ? '0 : head_q + 1'b1;
	assign rd_ptr_nx = (rd_ptr_q == '0) ? PTR_BITS'(WINDOW_MAX - 1) : rd_ptr_q - 1'b1;
	assign seen_inc = (seen_q == CNT_BITS'(WINDOW_MAX)) ? seen_q : seen_q + 1'b1;
	assign n_eff    = (seen_inc < len_eff) ? seen_inc : len_eff;

	always_comb begin
		if (window_length_q == '0) begin
			len_eff = CNT_BITS'(1);
		end else if (32'(window_length_q) > 32'(WINDOW_MAX)) begin
			len_eff = CNT_BITS'(WINDOW_MAX);
		end else begin
			len_eff = CNT_BITS'(window_length_q);
		end
	end

	always_comb begin
		for (int l = 0; l < 2; l++) begin
			mag[l]    = sum_q[l][SUM_BITS-1] ? SUM_BITS'(-sum_q[l]) : SUM_BITS'(sum_q[l]);
			div_a[l]  = div_bit(rem_q[l], dvd_q[l][DVD_EVEN-1], len_q);
			div_b[l]  = div_bit(div_a[l][CNT_BITS:1], dvd_q[l][DVD_EVEN-2], len_q);
			quo_ng[l] = -quo_q[l];
			avg[l]    = neg_q[l] ? quo_ng[l][AVG_BITS-1:0] : quo_q[l][AVG_BITS-1:0];
		end
	end

	always_comb begin
		state_d     = state_q;
		in_ch.ready = 1'b0;
		out_load    = 1'b0;
		case (state_q)
			dcmma_pkg::ST_IDLE: begin
				in_ch.ready = 1'b1;
				if (in_ch.valid) begin
					state_d = dcmma_pkg::ST_ACC;
				end
			end
			dcmma_pkg::ST_ACC: begin
				if (acc_done) begin
					state_d = dcmma_pkg::ST_DIV;
				end
			end
			dcmma_pkg::ST_DIV: begin
				if (step_q == STEP_BITS'(1)) begin
					state_d = dcmma_pkg::ST_FIN;
				end
			end
			dcmma_pkg::ST_FIN: begin
				if (!out_valid_q || out_ch.ready) begin
					out_load = 1'b1;
					state_d  = dcmma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = dcmma_pkg::ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q         <= dcmma_pkg::ST_IDLE;
			window_length_q <= dcmma_pkg::WINDOW_LENGTH_RESET;
			head_q          <= '0;
			seen_q          <= '0;
			cnt_q           <= '0;
			step_q          <= '0;
			rd_vld_s1       <= 1'b0;
			out_valid_q     <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				window_length_q <= cfg_data;
			end
			if (in_xfer) begin
				head_q <= head_nx;
				seen_q <= seen_inc;
				cnt_q  <= n_eff;
			end
			if (state_q == dcmma_pkg::ST_ACC) begin
				rd_vld_s1 <= (cnt_q != '0);
				if (cnt_q != '0) begin
					cnt_q <= cnt_q - 1'b1;
				end
				if (acc_done) begin
					step_q <= STEP_BITS'(ITER);
				end
			end
			if (state_q == dcmma_pkg::ST_DIV) begin
				step_q <= step_q - 1'b1;
			end
			if (out_load) begin
				out_valid_q <= 1'b1;
			end else if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_xfer) begin
			rd_ptr_q <= head_q;
			len_q    <= len_eff;
			for (int l = 0; l < 2; l++) begin
				hist_q[l][head_q] <= samp[l];
				sum_q[l]          <= '0;
				if (seen_q == '0 || samp[l] < min_q[l]) begin
					min_q[l] <= samp[l];
				end
				if (seen_q == '0 || samp[l] > max_q[l]) begin
					max_q[l] <= samp[l];
				end
			end
		end
		if (state_q == dcmma_pkg::ST_ACC) begin
			if (cnt_q != '0) begin
				rd_ptr_q <= rd_ptr_nx;
			end
			for (int l = 0; l < 2; l++) begin
				if (cnt_q != '0) begin
					rd_s1[l] <= hist_q[l][rd_ptr_q];
				end
				if (rd_vld_s1) begin
					sum_q[l] <= sum_q[l]
						+ {{(SUM_BITS - SAMPLE_BITS){rd_s1[l][SAMPLE_BITS-1]}}, rd_s1[l]};
				end
				if (acc_done) begin
					dvd_q[l] <= DVD_EVEN'({mag[l], {FRAC_BITS{1'b0}}});
					neg_q[l] <= sum_q[l][SUM_BITS-1];
					rem_q[l] <= '0;
					quo_q[l] <= '0;
				end
			end
		end
		if (state_q == dcmma_pkg::ST_DIV) begin
			for (int l = 0; l < 2; l++) begin
				dvd_q[l] <= {dvd_q[l][DVD_EVEN-3:0], 2'b00};
				rem_q[l] <= div_b[l][CNT_BITS:1];
				quo_q[l] <= {quo_q[l][DVD_EVEN-3:0], div_a[l][0], div_b[l][0]};
			end
		end
		if (out_load) begin
			for (int l = 0; l < 2; l++) begin
				out_min_q[l] <= min_q[l];
				out_max_q[l] <= max_q[l];
				out_avg_q[l] <= avg[l];
			end
		end
	end

	assign out_ch.valid           = out_valid_q;
	assign out_ch.min_temperature = out_min_q[LANE_TMP];
	assign out_ch.max_temperature = out_max_q[LANE_TMP];
	assign out_ch.avg_temperature = out_avg_q[LANE_TMP];
	assign out_ch.min_current     = out_min_q[LANE_CUR];
	assign out_ch.max_current     = out_max_q[LANE_CUR];
	assign out_ch.avg_current     = out_avg_q[LANE_CUR];

`ifndef SYNTHESIS
	a_busy_after_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		in_ch.valid && in_ch.ready |=> !in_ch.ready)
		else $error("input taken while sequencer busy");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		state_q != dcmma_pkg::ST_IDLE |->
			min_q[LANE_CUR] <= max_q[LANE_CUR] && min_q[LANE_TMP] <= max_q[LANE_TMP])
		else $error("running min above running max");

	a_cnt_le_seen: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= seen_q && seen_q <= CNT_BITS'(WINDOW_MAX))
		else $error("window count beyond samples held");

	a_rem_lt_div: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == dcmma_pkg::ST_DIV |-> rem_q[LANE_CUR] < len_q && rem_q[LANE_TMP] < len_q)
		else $error("divider remainder not below divisor");
`endif

endmodule

@@ verif/tb_dual_channel_min_max_moving_average_core.sv @@
// Testbench for dual_channel_min_max_moving_average_core: random-gap driver and monitor
// around the sample and result channels, checked against an in-bench min/max/average predictor.
// Depends on dcmma_pkg, dcmma_if.sv and the core RTL.
module tb_dual_channel_min_max_moving_average_core;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int SB        = dcmma_pkg::SAMPLE_BITS_DEF;
	localparam int AB        = dcmma_pkg::SAMPLE_BITS_DEF + dcmma_pkg::FRAC_BITS;
	localparam int WMAX      = dcmma_pkg::WINDOW_MAX_DEF;
	localparam int CB        = dcmma_pkg::CFG_BITS;
	localparam int CH_CUR    = 0;
	localparam int CH_TMP    = 1;
	localparam int MAX_GAP   = 17;
	localparam int SHOW_MAX  = 10;
	localparam int CYC_LIMIT = 400000;
	localparam int TAIL_CYC  = 40;
	localparam int RAND_ITEMS = 450;

	typedef struct {
		logic signed [SB-1:0] cur;
		logic signed [SB-1:0] tmp;
	} sample_t;

	typedef struct {
		logic signed [SB-1:0] min_t;
		logic signed [SB-1:0] max_t;
		logic signed [AB-1:0] avg_t;
		logic signed [SB-1:0] min_c;
		logic signed [SB-1:0] max_c;
		logic signed [AB-1:0] avg_c;
	} stats_t;

	logic                clk = 1'b0;
	logic                arst_n = 1'b0;
	logic                cfg_we = 1'b0;
	logic [CB-1:0]       cfg_data = '0;
	logic                in_valid = 1'b0;
	logic signed [SB-1:0] in_cur = '0;
	logic signed [SB-1:0] in_tmp = '0;
	logic                out_ready = 1'b0;

	dcmma_in_if  in_bus();
	dcmma_out_if out_bus();

	assign in_bus.valid              = in_valid;
	assign in_bus.current_sample     = in_cur;
	assign in_bus.temperature_sample = in_tmp;
	assign out_bus.ready             = out_ready;

	dual_channel_min_max_moving_average_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.cfg_we  (cfg_we),
		.cfg_data(cfg_data),
		.in_ch   (in_bus),
		.out_ch  (out_bus)
	);

	sample_t samples_pending[$];
	stats_t  stats_expected[$];

	logic signed [SB-1:0] hist [2][WMAX];
	logic signed [SB-1:0] run_min [2];
	logic signed [SB-1:0] run_max [2];
	logic [3:0]           ring_pos = '0;
	int                   seen_cnt = 0;
	logic [CB-1:0]        win_len = dcmma_pkg::WINDOW_LENGTH_RESET;

	int  mismatches = 0;
	int  cycles = 0;
	int  send_wait = 0;
	int  recv_wait = 0;
	bit  send_burst = 0;
	bit  recv_burst = 0;

	function automatic logic signed [AB-1:0] window_mean(input int ch, input int eff_len);
		longint acc;
		int     n;
		logic [3:0] idx;
		acc = 0;
		n = (seen_cnt < eff_len) ? seen_cnt : eff_len;
		for (int k = 0; k < n; k++) begin
			idx = 4'(ring_pos - 4'd1 - 4'(k));
			acc += hist[ch][idx];
		end
		acc = (acc * 256) / longint'(eff_len);
		return acc[AB-1:0];
	endfunction

	function automatic stats_t absorb_sample(input logic signed [SB-1:0] cur,
		input logic signed [SB-1:0] tmp);
		stats_t r;
		int     eff_len;
		logic signed [SB-1:0] s [2];
		s[CH_CUR] = cur;
		s[CH_TMP] = tmp;
		for (int ch = 0; ch < 2; ch++) begin
			hist[ch][ring_pos] = s[ch];
			if (seen_cnt == 0) begin
				run_min[ch] = s[ch];
				run_max[ch] = s[ch];
			end else begin
				if (s[ch] < run_min[ch]) run_min[ch] = s[ch];
				if (s[ch] > run_max[ch]) run_max[ch] = s[ch];
			end
		end
		ring_pos = ring_pos + 4'd1;
		if (seen_cnt < WMAX) seen_cnt++;
		eff_len = (win_len == 0) ? 1 : (win_len > WMAX) ? WMAX : int'(win_len);
		r.min_t = run_min[CH_TMP];
		r.max_t = run_max[CH_TMP];
		r.avg_t = window_mean(CH_TMP, eff_len);
		r.min_c = run_min[CH_CUR];
		r.max_c = run_max[CH_CUR];
		r.avg_c = window_mean(CH_CUR, eff_len);
		return r;
	endfunction

	function automatic int draw_gap(input bit burst);
		return burst ? 0 : int'($urandom_range(0, MAX_GAP));
	endfunction

	function automatic logic signed [SB-1:0] rand_sample();
		case ($urandom_range(0, 9))
			0: return -16'sd32768;
			1: return 16'sd32767;
			2, 3: return SB'(int'($urandom_range(0, 64)) - 32);
			default: return SB'($urandom);
		endcase
	endfunction

	task automatic queue_sample(input logic signed [SB-1:0] cur, input logic signed [SB-1:0] tmp);
		sample_t it;
		it.cur = cur;
		it.tmp = tmp;
		samples_pending.push_back(it);
	endtask

	task automatic wait_idle();
		do
			@(negedge clk);
		while (samples_pending.size() != 0 || in_valid || stats_expected.size() != 0);
	endtask

	task automatic set_window(input logic [CB-1:0] v);
		wait_idle();
		@(posedge clk);
		cfg_we   <= 1'b1;
		cfg_data <= v;
		@(posedge clk);
		cfg_we   <= 1'b0;
		win_len = v;
	endtask

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYC_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	always @(posedge clk) begin : drive
		sample_t it;
		int      gap;
		if (!arst_n) begin
			in_valid  <= 1'b0;
			send_wait <= 0;
		end else if (in_valid && in_bus.ready) begin
			stats_expected.push_back(absorb_sample(in_cur, in_tmp));
			if ($urandom_range(0, 39) == 0) send_burst = !send_burst;
			gap = draw_gap(send_burst);
			if (gap == 0 && samples_pending.size() != 0) begin
				it = samples_pending.pop_front();
				in_cur <= it.cur;
				in_tmp <= it.tmp;
			end else begin
				in_valid  <= 1'b0;
				send_wait <= (gap > 0) ? gap - 1 : 0;
			end
		end else if (!in_valid) begin
			if (send_wait != 0) begin
				send_wait <= send_wait - 1;
			end else if (samples_pending.size() != 0) begin
				it = samples_pending.pop_front();
				in_cur   <= it.cur;
				in_tmp   <= it.tmp;
				in_valid <= 1'b1;
			end
		end
	end

	always @(posedge clk) begin : watch
		stats_t want;
		stats_t got;
		int     gap;
		if (!arst_n) begin
			out_ready <= 1'b0;
			recv_wait <= 0;
		end else if (out_ready && out_bus.valid) begin
			got.min_t = out_bus.min_temperature;
			got.max_t = out_bus.max_temperature;
			got.avg_t = out_bus.avg_temperature;
			got.min_c = out_bus.min_current;
			got.max_c = out_bus.max_current;
			got.avg_c = out_bus.avg_current;
			if (stats_expected.size() == 0) begin
				mismatches++;
				if (mismatches <= SHOW_MAX)
					$display("unexpected transfer: min_t=%0d max_t=%0d avg_t=%0d ",
						got.min_t, got.max_t, got.avg_t,
						"min_c=%0d max_c=%0d avg_c=%0d",
						got.min_c, got.max_c, got.avg_c);
			end else begin
				want = stats_expected.pop_front();
				if (got.min_t !== want.min_t || got.max_t !== want.max_t
					|| got.avg_t !== want.avg_t || got.min_c !== want.min_c
					|| got.max_c !== want.max_c || got.avg_c !== want.avg_c) begin
					mismatches++;
					if (mismatches <= SHOW_MAX) begin
						$display("mismatch exp: min_t=%0d max_t=%0d avg_t=%0d ",
							want.min_t, want.max_t, want.avg_t,
							"min_c=%0d max_c=%0d avg_c=%0d",
							want.min_c, want.max_c, want.avg_c);
						$display("         got: min_t=%0d max_t=%0d avg_t=%0d ",
							got.min_t, got.max_t, got.avg_t,
							"min_c=%0d max_c=%0d avg_c=%0d",
							got.min_c, got.max_c, got.avg_c);
					end
				end
			end
			if ($urandom_range(0, 39) == 0) recv_burst = !recv_burst;
			gap = draw_gap(recv_burst);
			if (gap != 0) begin
				out_ready <= 1'b0;
				recv_wait <= gap - 1;
			end
		end else if (!out_ready) begin
			if (recv_wait != 0)
				recv_wait <= recv_wait - 1;
			else
				out_ready <= 1'b1;
		end
	end

	initial begin : stimulus
		int total;
		int n;
		int sel;
		logic [CB-1:0] w;
		logic signed [SB-1:0] hold_c;
		logic signed [SB-1:0] hold_t;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// reset window, min/max walking outward
		queue_sample(16'sd100, -16'sd50);
		queue_sample(16'sd200, -16'sd60);
		queue_sample(16'sd50, 16'sd10);
		queue_sample(-16'sd300, 16'sd400);
		queue_sample(16'sd0, 16'sd0);
		queue_sample(-16'sd1, -16'sd1);
		queue_sample(16'sd1, 16'sd1);

		// zero length acts as one
		set_window(5'd0);
		queue_sample(16'sd32767, -16'sd32768);
		queue_sample(-16'sd32768, 16'sd32767);
		queue_sample(-16'sd32768, 16'sd32767);

		// oversize length saturates; full window of extremes
		set_window(5'd31);
		for (int i = 0; i < WMAX; i++)
			queue_sample(16'sd32767, -16'sd32768);

		total = 0;
		while (total < RAND_ITEMS) begin
			sel = $urandom_range(0, 7);
			case (sel)
				0: w = 5'd0;
				1: w = 5'd1;
				2: w = 5'd16;
				3: w = 5'd31;
				4: w = CB'($urandom_range(17, 30));
				default: w = CB'($urandom_range(2, 15));
			endcase
			set_window(w);
			n = $urandom_range(15, 60);
			if (n > RAND_ITEMS - total) n = RAND_ITEMS - total;
			hold_c = rand_sample();
			hold_t = rand_sample();
			for (int i = 0; i < n; i++) begin
				if ($urandom_range(0, 3) == 0) begin
					queue_sample(hold_c, hold_t);
				end else begin
					hold_c = rand_sample();
					hold_t = rand_sample();
					queue_sample(hold_c, hold_t);
				end
			end
			total += n;
		end

		wait_idle();
		repeat (TAIL_CYC) @(posedge clk);
		if (mismatches == 0 && stats_expected.size() == 0)
			$display("[ OK ] regression clean");
		else
			$display("[FAIL] regression broken");
		$finish;
	end

endmodule
